[rtl/fdf_pkg.sv]
// Shared constants, state encoding and arctangent table for the fingertip defect filter.
// No dependencies; imported by the filter and its checker.
package fdf_pkg;

  localparam int COORD_BITS   = 12;
  localparam int THR_BITS     = 12;
  localparam int CORDIC_STEPS = 16;
  localparam int PRESCALE     = 16;
  localparam int ATAN_TAB_LEN = 24;
  localparam int TAB_BITS     = $clog2(ATAN_TAB_LEN);
  localparam int ANG_BITS     = 14;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;
  localparam int CNT_BITS     = $clog2(CORDIC_ITERS);
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int DP_BITS      = DIFF_BITS + PRESCALE + 3;
  localparam int Z_BITS       = 18;
  localparam int QUARTER_TURN = 90 * 256;
  localparam int ANGLE_LIMIT  = 90 * 256;
  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(50);

  localparam logic KIND_TIP    = 1'b0;
  localparam logic KIND_VALLEY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_LOAD,
    S_ITER,
    S_DECIDE,
    S_TIP,
    S_CLOSE
  } fdf_state_t;

  // atan(2^-i) in 1/256 degree, rounded
  function automatic logic [ANG_BITS-1:0] atan_tab(input logic [TAB_BITS-1:0] idx);
    logic [ANG_BITS-1:0] v;
    case (idx)
      TAB_BITS'(0):  v = ANG_BITS'(11520);
      TAB_BITS'(1):  v = ANG_BITS'(6801);
      TAB_BITS'(2):  v = ANG_BITS'(3593);
      TAB_BITS'(3):  v = ANG_BITS'(1824);
      TAB_BITS'(4):  v = ANG_BITS'(916);
      TAB_BITS'(5):  v = ANG_BITS'(458);
      TAB_BITS'(6):  v = ANG_BITS'(229);
      TAB_BITS'(7):  v = ANG_BITS'(115);
      TAB_BITS'(8):  v = ANG_BITS'(57);
      TAB_BITS'(9):  v = ANG_BITS'(29);
      TAB_BITS'(10): v = ANG_BITS'(14);
      TAB_BITS'(11): v = ANG_BITS'(7);
      TAB_BITS'(12): v = ANG_BITS'(4);
      TAB_BITS'(13): v = ANG_BITS'(2);
      TAB_BITS'(14): v = ANG_BITS'(1);
      default:       v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/fingertip_defect_filter.sv]
// Fingertip defect filter: depth and centre-line tests, CORDIC angle test, leftmost valley.
// Depends on fdf_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat per convexity defect, or a beat with
//   has_defect low that only closes a frame via frame_end.
//   Output channel (out_valid/out_ready): kind 0 beats carry a fingertip (defect start
//   point); a kind 1 beat carries the frame's leftmost passing end point, with found,
//   and has last set. An input beat yields zero, one or two output beats.
//   Configuration: cfg_we writes cfg_wdata into the threshold register; write only idle.
// Flow control:
//   in_ready is high only while idle, so a new beat is taken only after the last one is
//   done. A beat that passes the depth and centre-line tests runs one shared shift-add
//   CORDIC unit twice in turn; a beat that fails them skips the CORDIC unit.
// Reset (rst_n low, synchronous): threshold returns to 50, the kept point and output
//   valid clear, and the sequencer goes idle.
// Stall: a held result stays in the output register; the sequencer waits before writing
//   another result, while a new input beat may still be taken when idle.
module fingertip_defect_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fdf_pkg::THR_BITS-1:0]    cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_has_defect,
  input  logic [fdf_pkg::COORD_BITS-1:0]  in_start_x,
  input  logic [fdf_pkg::COORD_BITS-1:0]  in_start_y,
  input  logic [fdf_pkg::COORD_BITS-1:0]  in_end_x,
  input  logic [fdf_pkg::COORD_BITS-1:0]  in_end_y,
  input  logic [fdf_pkg::COORD_BITS-1:0]  in_far_x,
  input  logic [fdf_pkg::COORD_BITS-1:0]  in_far_y,
  input  logic [fdf_pkg::COORD_BITS-1:0]  in_center_y,
  input  logic                            in_frame_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [fdf_pkg::COORD_BITS-1:0]  out_point_x,
  output logic [fdf_pkg::COORD_BITS-1:0]  out_point_y,
  output logic                            out_found,
  output logic                            out_last
);
  import fdf_pkg::*;

  fdf_state_t state_r, state_nxt;

  logic                  sel_r, sel_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic signed [DP_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_BITS-1:0]  z_r, z_nxt, beta_r, beta_nxt;
  logic                  zero_r, zero_nxt;

  logic                  has_r, has_nxt, fe_r, fe_nxt;
  logic [COORD_BITS-1:0] sx_r, sx_nxt, sy_r, sy_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  logic [COORD_BITS-1:0] fx_r, fx_nxt, fy_r, fy_nxt, cy_r, cy_nxt;
  logic [THR_BITS-1:0]   thr_r, thr_nxt;

  logic [COORD_BITS-1:0] ref_x_r, ref_x_nxt, ref_y_r, ref_y_nxt;
  logic                  ref_v_r, ref_v_nxt;

  logic                  out_valid_r, out_valid_nxt, out_kind_r, out_kind_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                  out_found_r, out_found_nxt, out_last_r, out_last_nxt;

  localparam int SUM_BITS = (COORD_BITS > THR_BITS ? COORD_BITS : THR_BITS) + 1;

  logic [SUM_BITS-1:0]        depth_lim, line_lim;
  logic                       tests_ok;
  logic signed [DIFF_BITS-1:0] num, den;
  logic signed [DP_BITS-1:0]  ld_x, ld_y, ld_nx, ld_ny, xsh, ysh;
  logic signed [Z_BITS-1:0]   ld_z, it_z, tab_z, alpha;
  logic signed [DP_BITS-1:0]  it_x, it_y;
  logic signed [Z_BITS:0]     ang_sum;
  logic                       slot_free;

  always_comb begin
    depth_lim = SUM_BITS'(ey_r) + SUM_BITS'(thr_r);
    line_lim  = SUM_BITS'(cy_r) + SUM_BITS'(thr_r);
    tests_ok  = (SUM_BITS'(fy_r) > depth_lim) && (SUM_BITS'(fy_r) < line_lim) &&
                (SUM_BITS'(ey_r) < line_lim) && (SUM_BITS'(sy_r) < line_lim);
  end

  always_comb begin
    if (sel_r) begin
      num = $signed({1'b0, ex_r}) - $signed({1'b0, fx_r});
      den = $signed({1'b0, ey_r}) - $signed({1'b0, fy_r});
    end else begin
      num = $signed({1'b0, fx_r}) - $signed({1'b0, sx_r});
      den = $signed({1'b0, fy_r}) - $signed({1'b0, sy_r});
    end
    ld_nx = $signed(DP_BITS'(den)) <<< PRESCALE;
    ld_ny = $signed(DP_BITS'(num)) <<< PRESCALE;
    if (ld_nx < 0) begin
      if (ld_ny >= 0) begin
        ld_x = ld_ny;
        ld_y = -ld_nx;
        ld_z = Z_BITS'(QUARTER_TURN);
      end else begin
        ld_x = -ld_ny;
        ld_y = ld_nx;
        ld_z = -Z_BITS'(QUARTER_TURN);
      end
    end else begin
      ld_x = ld_nx;
      ld_y = ld_ny;
      ld_z = '0;
    end
  end

  // shared shift-add unit: one CORDIC vectoring step per cycle
  always_comb begin
    xsh   = x_r >>> cnt_r;
    ysh   = y_r >>> cnt_r;
    tab_z = $signed(Z_BITS'(atan_tab(TAB_BITS'(cnt_r))));
    if (y_r >= 0) begin
      it_x = x_r + ysh;
      it_y = y_r - xsh;
      it_z = z_r + tab_z;
    end else begin
      it_x = x_r - ysh;
      it_y = y_r + xsh;
      it_z = z_r - tab_z;
    end
    alpha   = zero_r ? '0 : z_r;
    ang_sum = (Z_BITS+1)'(beta_r) + (Z_BITS+1)'(alpha);
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    zero_nxt      = zero_r;
    beta_nxt      = beta_r;
    has_nxt       = has_r;
    fe_nxt        = fe_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    cy_nxt        = cy_r;
    thr_nxt       = cfg_we ? cfg_wdata : thr_r;
    ref_x_nxt     = ref_x_r;
    ref_y_nxt     = ref_y_r;
    ref_v_nxt     = ref_v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          has_nxt   = in_has_defect;
          fe_nxt    = in_frame_end;
          sx_nxt    = in_start_x;
          sy_nxt    = in_start_y;
          ex_nxt    = in_end_x;
          ey_nxt    = in_end_y;
          fx_nxt    = in_far_x;
          fy_nxt    = in_far_y;
          cy_nxt    = in_center_y;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        sel_nxt   = 1'b0;
        state_nxt = (has_r && tests_ok) ? S_LOAD : S_CLOSE;
      end
      S_LOAD: begin
        x_nxt     = ld_x;
        y_nxt     = ld_y;
        z_nxt     = ld_z;
        zero_nxt  = (num == '0) && (den == '0);
        cnt_nxt   = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        x_nxt   = it_x;
        y_nxt   = it_y;
        z_nxt   = it_z;
        cnt_nxt = cnt_r + CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(CORDIC_ITERS - 1)) begin
          if (!sel_r) begin
            beta_nxt  = zero_r ? '0 : it_z;
            sel_nxt   = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (ang_sum <= (Z_BITS+1)'(ANGLE_LIMIT)) begin
          if (!ref_v_r || ex_r < ref_x_r) begin
            ref_x_nxt = ex_r;
            ref_y_nxt = ey_r;
            ref_v_nxt = 1'b1;
          end
          state_nxt = S_TIP;
        end else begin
          state_nxt = S_CLOSE;
        end
      end
      S_TIP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_TIP;
          out_x_nxt     = sx_r;
          out_y_nxt     = sy_r;
          out_found_nxt = 1'b0;
          out_last_nxt  = 1'b0;
          state_nxt     = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (!fe_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_VALLEY;
          out_x_nxt     = ref_v_r ? ref_x_r : '0;
          out_y_nxt     = ref_v_r ? ref_y_r : '0;
          out_found_nxt = ref_v_r;
          out_last_nxt  = 1'b1;
          ref_x_nxt     = '0;
          ref_y_nxt     = '0;
          ref_v_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THR_RESET;
      ref_x_r     <= '0;
      ref_y_r     <= '0;
      ref_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      ref_x_r     <= ref_x_nxt;
      ref_y_r     <= ref_y_nxt;
      ref_v_r     <= ref_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r       <= sel_nxt;
    cnt_r       <= cnt_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
    zero_r      <= zero_nxt;
    beta_r      <= beta_nxt;
    has_r       <= has_nxt;
    fe_r        <= fe_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    fx_r        <= fx_nxt;
    fy_r        <= fy_nxt;
    cy_r        <= cy_nxt;
    out_kind_r  <= out_kind_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;
  assign out_found   = out_found_r;
  assign out_last    = out_last_r;

endmodule

[rtl/fdf_checker.sv]
// Port-level checker for the fingertip defect filter, bound to the top level.
// Depends on fdf_pkg and fingertip_defect_filter.
module fdf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_kind,
  input logic [fdf_pkg::COORD_BITS-1:0] out_point_x,
  input logic [fdf_pkg::COORD_BITS-1:0] out_point_y,
  input logic                           out_found,
  input logic                           out_last
);
  import fdf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_x) && $stable(out_point_y))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the item was processed");

  a_tip_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TIP |-> !out_found && !out_last)
    else $error("fingertip beat carries found or last");

  a_valley_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_VALLEY |->
      out_last && (out_found || (out_point_x == '0 && out_point_y == '0)))
    else $error("valley beat malformed");

endmodule

bind fingertip_defect_filter fdf_checker u_fdf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_kind    (out_kind),
  .out_point_x (out_point_x),
  .out_point_y (out_point_y),
  .out_found   (out_found),
  .out_last    (out_last)
);
